@@ hw/rtl/skvcd_pkg.sv @@
// ============================================================================
// skvcd_pkg
// Shared types, constants and character helpers for the key=value decoder.
// ============================================================================
package skvcd_pkg;

    // Line buffer size in bytes; the default for the top level parameter
    localparam int unsigned LINE_BUFFER_BYTES_DEF = 64;

    // Depth of the queue between the front and the back part
    localparam int unsigned QUEUE_DEPTH = 2;

    // Register reset values
    localparam logic [15:0] TIME_LOW_RESET  = 16'd50;
    localparam logic [15:0] TIME_HIGH_RESET = 16'(5 * 60 * 100);

    // Register indexes (decoded from paddr[2])
    localparam logic REG_TIME_LOW  = 1'b0;
    localparam logic REG_TIME_HIGH = 1'b1;

    // Response status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_NO_SEP   = 3'd2;
    localparam logic [2:0] ST_BAD_KEY  = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Key lengths
    localparam logic [2:0] KEY_TIME_LEN  = 3'd4;
    localparam logic [2:0] KEY_RESET_LEN = 3'd5;

    // Summary of one finished line, handed from the front to the back
    typedef struct packed {
        logic        length_error;
        logic        separator_seen;
        logic        key_is_time;
        logic        key_is_reset;
        logic        number_negative;
        logic [15:0] number_value;
    } line_summary_t;

    // Queue fill status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Characters of "time"
    function automatic logic [7:0] time_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h74; // t
            3'd1:    ch = 8'h69; // i
            3'd2:    ch = 8'h6D; // m
            3'd3:    ch = 8'h65; // e
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Characters of "reset"
    function automatic logic [7:0] reset_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h72; // r
            3'd1:    ch = 8'h65; // e
            3'd2:    ch = 8'h73; // s
            3'd3:    ch = 8'h65; // e
            3'd4:    ch = 8'h74; // t
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ hw/rtl/skvcd_front.sv @@
// ============================================================================
// skvcd_front
// Takes received bytes, tracks key match and value parse, and pushes a line
// summary into the queue at each CR or LF.
// ============================================================================
module skvcd_front #(
    parameter int unsigned LINE_BUFFER_BYTES = skvcd_pkg::LINE_BUFFER_BYTES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     byte_valid,
    output logic                     byte_ready,
    input  logic [7:0]               byte_data,
    input  skvcd_pkg::queue_status_t q_stat,
    output logic                     push,
    output skvcd_pkg::line_summary_t push_item
);
    import skvcd_pkg::*;

    localparam int unsigned CNT_W = $clog2(LINE_BUFFER_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_BUFFER_BYTES - 2);

    // Value parser phases
    typedef enum logic [3:0] {
        PH_SPACE  = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             len_err_reg, len_err_next;
    logic             ended_reg, ended_next;
    logic             sep_reg, sep_next;
    logic [2:0]       kpos_reg, kpos_next;
    logic             is_time_reg, is_time_next;
    logic             is_reset_reg, is_reset_next;
    phase_t           phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [15:0]      value_reg, value_next;

    logic             take;
    logic             is_term;
    logic             is_ws;
    logic             is_sign;
    logic             is_digit;
    logic [19:0]      value_x10;
    logic [19:0]      value_sum;

    assign byte_ready = !q_stat.full;
    assign take       = byte_valid && byte_ready;
    assign is_term    = (byte_data == CH_CR) || (byte_data == CH_LF);
    assign is_ws      = (byte_data == CH_SPACE) || (byte_data == CH_TAB) ||
                        (byte_data == CH_VT) || (byte_data == CH_FF);
    assign is_sign    = (byte_data == CH_PLUS) || (byte_data == CH_MINUS);
    assign is_digit   = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);

    // value*10 + digit, saturated to 16 bits
    assign value_x10  = {1'b0, value_reg, 3'b000} + {3'b000, value_reg, 1'b0};
    assign value_sum  = value_x10 + {16'd0, byte_data[3:0]};

    // Line summary goes out on a terminator
    assign push = take && is_term;
    always_comb
    begin
        push_item.length_error    = len_err_reg;
        push_item.separator_seen  = sep_reg;
        push_item.key_is_time     = is_time_reg;
        push_item.key_is_reset    = is_reset_reg;
        push_item.number_negative = neg_reg;
        push_item.number_value    = value_reg;
    end

    // Per-byte line state update
    always_comb
    begin
        count_next    = count_reg;
        len_err_next  = len_err_reg;
        ended_next    = ended_reg;
        sep_next      = sep_reg;
        kpos_next     = kpos_reg;
        is_time_next  = is_time_reg;
        is_reset_next = is_reset_reg;
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        value_next    = value_reg;

        if (take) begin
            if (is_term) begin
                // line end: clear everything
                count_next    = '0;
                len_err_next  = 1'b0;
                ended_next    = 1'b0;
                sep_next      = 1'b0;
                kpos_next     = '0;
                is_time_next  = 1'b1;
                is_reset_next = 1'b1;
                phase_next    = PH_SPACE;
                neg_next      = 1'b0;
                value_next    = '0;
            end else if (count_reg >= CNT_LIMIT) begin
                len_err_next = 1'b1;
            end else begin
                count_next = count_reg + 1'b1;
                if (ended_reg) begin
                    // rest of the line ignored after a zero byte
                end else if (byte_data == CH_NUL) begin
                    ended_next = 1'b1;
                end else if (sep_reg) begin
                    // value part
                    if (phase_reg == PH_SPACE && is_sign) begin
                        neg_next   = (byte_data == CH_MINUS);
                        phase_next = PH_SIGN;
                    end else if (phase_reg == PH_SPACE && is_ws) begin
                        phase_next = PH_SPACE;
                    end else if (phase_reg != PH_DONE) begin
                        if (is_digit) begin
                            value_next = (value_sum > 20'hFFFF) ? 16'hFFFF : value_sum[15:0];
                            phase_next = PH_DIGITS;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                end else if (byte_data == CH_EQ) begin
                    sep_next      = 1'b1;
                    is_time_next  = is_time_reg && (kpos_reg == KEY_TIME_LEN);
                    is_reset_next = is_reset_reg && (kpos_reg == KEY_RESET_LEN);
                end else begin
                    // key part
                    is_time_next  = is_time_reg && (kpos_reg < KEY_TIME_LEN) &&
                                    (time_char(kpos_reg) == byte_data);
                    is_reset_next = is_reset_reg && (kpos_reg < KEY_RESET_LEN) &&
                                    (reset_char(kpos_reg) == byte_data);
                    if (kpos_reg != 3'd7) begin
                        kpos_next = kpos_reg + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg    <= '0;
            len_err_reg  <= 1'b0;
            ended_reg    <= 1'b0;
            sep_reg      <= 1'b0;
            kpos_reg     <= '0;
            is_time_reg  <= 1'b1;
            is_reset_reg <= 1'b1;
            phase_reg    <= PH_SPACE;
            neg_reg      <= 1'b0;
            value_reg    <= '0;
        end else begin
            count_reg    <= count_next;
            len_err_reg  <= len_err_next;
            ended_reg    <= ended_next;
            sep_reg      <= sep_next;
            kpos_reg     <= kpos_next;
            is_time_reg  <= is_time_next;
            is_reset_reg <= is_reset_next;
            phase_reg    <= phase_next;
            neg_reg      <= neg_next;
            value_reg    <= value_next;
        end
    end

endmodule

@@ hw/rtl/skvcd_queue.sv @@
// ============================================================================
// skvcd_queue
// Small first-in first-out queue of line summaries between front and back.
// ============================================================================
module skvcd_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  skvcd_pkg::line_summary_t push_item,
    input  logic                     pop,
    output skvcd_pkg::line_summary_t pop_item,
    output skvcd_pkg::queue_status_t q_stat
);
    import skvcd_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    line_summary_t    entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_item     = entries_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/skvcd_back.sv @@
// ============================================================================
// skvcd_back
// Turns a line summary into a response and holds it in the output register.
// ============================================================================
module skvcd_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  skvcd_pkg::queue_status_t q_stat,
    input  skvcd_pkg::line_summary_t pop_item,
    output logic                     pop,
    input  logic [15:0]              time_low_limit,
    input  logic [15:0]              time_high_limit,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               out_status,
    output logic                     out_time_write,
    output logic [15:0]              out_time_value,
    output logic                     out_reset_request
);
    import skvcd_pkg::*;

    logic        valid_reg, valid_next;
    logic [2:0]  status_reg, status_next;
    logic        twrite_reg, twrite_next;
    logic [15:0] tval_reg, tval_next;
    logic        rreq_reg, rreq_next;
    logic        is_neg;
    logic        in_range;

    // Output register free or being emptied this cycle
    assign pop      = !q_stat.empty && (!valid_reg || out_ready);
    assign is_neg   = pop_item.number_negative && (pop_item.number_value != 16'd0);
    assign in_range = !is_neg && (pop_item.number_value >= time_low_limit) &&
                      (pop_item.number_value <= time_high_limit);

    // Response decode, priority as listed
    always_comb
    begin
        status_next = ST_OK;
        twrite_next = 1'b0;
        tval_next   = '0;
        rreq_next   = 1'b0;
        if (pop_item.length_error) begin
            status_next = ST_TOO_LONG;
        end else if (!pop_item.separator_seen) begin
            status_next = ST_NO_SEP;
        end else if (pop_item.key_is_time) begin
            if (in_range) begin
                twrite_next = 1'b1;
                tval_next   = pop_item.number_value;
            end else begin
                status_next = ST_RANGE;
            end
        end else if (pop_item.key_is_reset) begin
            rreq_next = 1'b1;
        end else begin
            status_next = ST_BAD_KEY;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            status_reg <= status_next;
            twrite_reg <= twrite_next;
            tval_reg   <= tval_next;
            rreq_reg   <= rreq_next;
        end
    end

    assign out_valid         = valid_reg;
    assign out_status        = status_reg;
    assign out_time_write    = twrite_reg;
    assign out_time_value    = tval_reg;
    assign out_reset_request = rreq_reg;

endmodule

@@ hw/rtl/serial_key_value_command_decoder_core.sv @@
// ============================================================================
// serial_key_value_command_decoder_core
// Serial key=value line decoder: "time=<n>" sets a cycle time, "reset=" asks
// for a system reset, one response item per CR or LF.
//
//   channel   dir  width  carries
//   s_axis    in   8      rx_byte, one item per received character
//   m_axis    out  24     one response per line end
//   apb       in   32     time_low_limit (0x0), time_high_limit (0x4)
//
// One byte is taken per cycle while s_tready is high; after its terminator
// is accepted, a line response is held in the queue, then the output register.
// s_tready drops only while the two-entry line queue is full, i.e. when two
// line summaries wait behind a response held in the output register by
// m_tready low. rst_n clears line state and the limits to 50 and 30000; no
// clearing pass is needed.
// ============================================================================
module serial_key_value_command_decoder_core #(
    parameter int unsigned LINE_BUFFER_BYTES = skvcd_pkg::LINE_BUFFER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] status, [3] time_write,
                                   // [19:4] time_value, [20] reset_request
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import skvcd_pkg::*;

    logic [15:0]   time_low_reg;
    logic [15:0]   time_high_reg;
    logic          cfg_write;

    logic          push;
    logic          pop;
    line_summary_t push_item;
    line_summary_t pop_item;
    queue_status_t q_stat;

    logic [2:0]    out_status;
    logic          out_time_write;
    logic [15:0]   out_time_value;
    logic          out_reset_request;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_low_reg  <= TIME_LOW_RESET;
            time_high_reg <= TIME_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_TIME_LOW:  time_low_reg  <= pwdata[15:0];
                REG_TIME_HIGH: time_high_reg <= pwdata[15:0];
                default:       time_low_reg  <= time_low_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TIME_LOW:  prdata = {16'd0, time_low_reg};
            REG_TIME_HIGH: prdata = {16'd0, time_high_reg};
            default:       prdata = '0;
        endcase
    end

    // Front: byte intake and line tracking
    skvcd_front #(
        .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(s_tvalid),
        .byte_ready(s_tready),
        .byte_data (s_tdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    // Line summary queue
    skvcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_item(push_item),
        .pop      (pop),
        .pop_item (pop_item),
        .q_stat   (q_stat)
    );

    // Back: response decode and output register
    skvcd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_stat           (q_stat),
        .pop_item         (pop_item),
        .pop              (pop),
        .time_low_limit   (time_low_reg),
        .time_high_limit  (time_high_reg),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_status       (out_status),
        .out_time_write   (out_time_write),
        .out_time_value   (out_time_value),
        .out_reset_request(out_reset_request)
    );

    assign m_tdata = {3'b000, out_reset_request, out_time_value, out_time_write, out_status};

    // Checks
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("line summary pushed into a full queue");

    a_term_push: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tdata == CH_CR || s_tdata == CH_LF)) |-> push)
        else $error("accepted terminator gave no line summary");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status != ST_OK) |-> (!out_time_write && !out_reset_request))
        else $error("error response carries a time write or reset request");

    a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> m_tvalid)
        else $error("popped line summary did not reach the output register");

endmodule
